### design/i2cm_pkg.sv
package i2cm_pkg;

    typedef logic [2:0] t_phase;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] REG_CTRL = 2'd0;
    localparam logic [1:0] REG_STAT = 2'd1;
    localparam logic [1:0] REG_BUF  = 2'd2;
    localparam logic [1:0] REG_FLAG = 2'd3;

    localparam t_phase PH_IDLE    = 3'd0;
    localparam t_phase PH_START   = 3'd1;
    localparam t_phase PH_RESTART = 3'd2;
    localparam t_phase PH_STOP    = 3'd3;
    localparam t_phase PH_TX      = 3'd4;
    localparam t_phase PH_RX      = 3'd5;
    localparam t_phase PH_ACK     = 3'd6;

    localparam logic [4:0] REQ_MASK    = 5'h1F;
    localparam logic [7:0] STAT_TX     = 8'h04;
    localparam int         CTL_ACK_BIT = 5;
    localparam int         STAT_COLL   = 7;

    localparam logic [3:0] NBITS_TX  = 4'd9;
    localparam logic [3:0] NBITS_RX  = 4'd8;
    localparam logic [3:0] NBITS_ACK = 4'd1;
    localparam logic [3:0] ACK_SLOT  = 4'b1000;

    localparam logic [2:0] LEN_START   = 3'd2;
    localparam logic [2:0] LEN_RESTART = 3'd4;
    localparam logic [2:0] LEN_STOP    = 3'd3;

    localparam logic [7:0] DIV_RESET = 8'd3;

    typedef struct packed {
        logic [1:0] operation;
        logic [1:0] reg_select;
        logic [7:0] write_data;
        logic       sda_sample;
        logic       scl_sample;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       scl_pull_low;
        logic       sda_pull_low;
        logic       done_irq;
        logic       busy_res;
    } t_result;

endpackage

### design/i2cm_if.sv
interface i2cm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [1:0] reg_select;
    logic [7:0] write_data;
    logic       sda_sample;
    logic       scl_sample;

    modport source (output valid, output operation, output reg_select, output write_data,
                    output sda_sample, output scl_sample, input ready);
    modport sink   (input valid, input operation, input reg_select, input write_data,
                    input sda_sample, input scl_sample, output ready);
endinterface

interface i2cm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       scl_pull_low;
    logic       sda_pull_low;
    logic       done_irq;
    logic       busy_res;

    modport source (output valid, output read_data, output scl_pull_low, output sda_pull_low,
                    output done_irq, output busy_res, input ready);
    modport sink   (input valid, input read_data, input scl_pull_low, input sda_pull_low,
                    input done_irq, input busy_res, output ready);
endinterface

### design/i2cm_apb.sv
module i2cm_apb
    import i2cm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  o_div
);

    logic [7:0] r_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div <= DIV_RESET;
        end else if (psel && penable && pwrite && (paddr == 2'd0)) begin
            r_div <= pwdata[7:0];
        end
    end

    assign prdata = (paddr == 2'd0) ? {24'd0, r_div} : 32'd0;
    assign pready = 1'b1;
    assign o_div  = r_div;

endmodule

### design/i2cm_engine.sv
module i2cm_engine
    import i2cm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  t_item      i_item,
    input  logic [7:0] i_div,
    output t_result    o_res
);

    t_phase     r_phase, n_phase;
    logic [3:0] r_bit_cnt, n_bit_cnt;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_baud, n_baud;
    logic [7:0] r_buf, n_buf;
    logic [1:0] r_quarter, n_quarter;
    logic       r_ack_status, n_ack_status;
    logic       r_ack_data, n_ack_data;
    logic       r_done, n_done;
    logic       r_coll, n_coll;
    logic       r_scl, n_scl;
    logic       r_sda, n_sda;

    logic       w_busy, w_bitwise, w_fin, w_app, w_beg;
    t_phase     w_beg_ph;
    logic [2:0] w_qn, w_len;
    logic [3:0] w_bn, w_nbits;
    logic [4:0] w_req, w_ctl;
    logic [7:0] w_rd;

    function automatic logic [1:0] f_drive(input t_phase ph, input logic [1:0] q,
                                           input logic [3:0] bc, input logic [7:0] sh,
                                           input logic ack_d, input logic [1:0] cur);
        logic [1:0] d;
        d = cur;
        unique case (ph)
            PH_START:   d = {(q >= 2'd1), 1'b1};
            PH_RESTART: d = {(q == 2'd0) || (q == 2'd3), (q >= 2'd2)};
            PH_STOP:    d = {(q == 2'd0), (q <= 2'd1)};
            PH_TX:      d = {(q < 2'd2), (bc < ACK_SLOT) ? ~sh[7] : 1'b0};
            PH_RX:      d = {(q < 2'd2), 1'b0};
            PH_ACK:     d = {(q < 2'd2), ~ack_d};
            default:    d = cur;
        endcase
        return d;
    endfunction

    assign w_busy    = (r_phase != PH_IDLE);
    assign w_bitwise = (r_phase == PH_TX) || (r_phase == PH_RX) || (r_phase == PH_ACK);
    assign w_qn      = {1'b0, r_quarter} + 3'd1;
    assign w_bn      = r_bit_cnt + 4'd1;
    assign w_nbits   = (r_phase == PH_TX) ? NBITS_TX : (r_phase == PH_RX) ? NBITS_RX : NBITS_ACK;
    assign w_len     = (r_phase == PH_START) ? LEN_START :
                       (r_phase == PH_RESTART) ? LEN_RESTART : LEN_STOP;
    assign w_req     = i_item.write_data[4:0] & REQ_MASK;

    always_comb begin
        unique case (r_phase)
            PH_START:   w_ctl = 5'h01;
            PH_RESTART: w_ctl = 5'h02;
            PH_STOP:    w_ctl = 5'h04;
            PH_RX:      w_ctl = 5'h08;
            PH_ACK:     w_ctl = 5'h10;
            default:    w_ctl = 5'h00;
        endcase
    end

    always_comb begin
        n_phase      = r_phase;
        n_bit_cnt    = r_bit_cnt;
        n_shift      = r_shift;
        n_baud       = r_baud;
        n_buf        = r_buf;
        n_quarter    = r_quarter;
        n_ack_status = r_ack_status;
        n_ack_data   = r_ack_data;
        n_done       = r_done;
        n_coll       = r_coll;
        n_scl        = r_scl;
        n_sda        = r_sda;
        w_rd         = 8'd0;
        w_fin        = 1'b0;
        w_app        = 1'b0;
        w_beg        = 1'b0;
        w_beg_ph     = PH_IDLE;

        unique case (i_item.operation)
            OP_TICK: begin
                if (w_busy && (r_scl || i_item.scl_sample)) begin
                    if (r_baud < i_div) begin
                        n_baud = r_baud + 8'd1;
                    end else begin
                        n_baud = 8'd0;
                        if (w_bitwise) begin
                            if (r_quarter == 2'd2) begin
                                if ((r_phase == PH_TX) && (r_bit_cnt == ACK_SLOT)) begin
                                    n_ack_status = i_item.sda_sample;
                                end else if (r_phase == PH_RX) begin
                                    n_shift = {r_shift[6:0], i_item.sda_sample};
                                end
                            end
                            if (r_quarter == 2'd3) begin
                                n_quarter = 2'd0;
                                if (r_phase == PH_TX) begin
                                    n_shift = {r_shift[6:0], 1'b0};
                                end
                                n_bit_cnt = w_bn;
                                if (w_bn >= w_nbits) begin
                                    w_fin = 1'b1;
                                end else begin
                                    w_app = 1'b1;
                                end
                            end else begin
                                n_quarter = w_qn[1:0];
                                w_app     = 1'b1;
                            end
                        end else begin
                            if (w_qn >= w_len) begin
                                w_fin = 1'b1;
                            end else begin
                                n_quarter = w_qn[1:0];
                                w_app     = 1'b1;
                            end
                        end
                    end
                end
            end
            OP_WRITE: begin
                unique case (i_item.reg_select)
                    REG_CTRL: begin
                        if ((w_req != 5'd0) && w_busy) begin
                            n_coll = 1'b1;
                        end else begin
                            n_ack_data = i_item.write_data[CTL_ACK_BIT];
                            w_beg      = (w_req != 5'd0);
                            if (w_req[0]) begin
                                w_beg_ph = PH_START;
                            end else if (w_req[1]) begin
                                w_beg_ph = PH_RESTART;
                            end else if (w_req[2]) begin
                                w_beg_ph = PH_STOP;
                            end else if (w_req[3]) begin
                                w_beg_ph = PH_RX;
                            end else begin
                                w_beg_ph = PH_ACK;
                            end
                        end
                    end
                    REG_STAT: n_coll = i_item.write_data[STAT_COLL];
                    REG_BUF: begin
                        if (w_busy) begin
                            n_coll = 1'b1;
                        end else begin
                            n_buf    = i_item.write_data;
                            n_shift  = i_item.write_data;
                            w_beg    = 1'b1;
                            w_beg_ph = PH_TX;
                        end
                    end
                    default: n_done = i_item.write_data[0];
                endcase
            end
            OP_READ: begin
                unique case (i_item.reg_select)
                    REG_CTRL: w_rd = {1'b0, r_ack_status, r_ack_data, w_ctl};
                    REG_STAT: w_rd = {r_coll, 6'd0, w_busy} |
                                     ((r_phase == PH_TX) ? STAT_TX : 8'h00);
                    REG_BUF:  w_rd = r_buf;
                    default:  w_rd = {7'd0, r_done};
                endcase
            end
            default: ;
        endcase

        if (w_beg) begin
            n_phase   = w_beg_ph;
            n_bit_cnt = 4'd0;
            n_quarter = 2'd0;
            n_baud    = 8'd0;
            if (w_beg_ph == PH_RX) begin
                n_shift = 8'd0;
            end
            w_app = 1'b1;
        end

        if (w_fin) begin
            if (r_phase == PH_STOP) begin
                n_scl = 1'b0;
                n_sda = 1'b0;
            end else if (w_bitwise) begin
                if (r_phase == PH_RX) begin
                    n_buf = n_shift;
                end
                n_scl = 1'b1;
                n_sda = 1'b0;
            end
            n_phase   = PH_IDLE;
            n_bit_cnt = 4'd0;
            n_quarter = 2'd0;
            n_baud    = 8'd0;
            n_done    = 1'b1;
        end

        if (w_app) begin
            {n_scl, n_sda} = f_drive(n_phase, n_quarter, n_bit_cnt, n_shift, n_ack_data,
                                     {n_scl, n_sda});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit_cnt    <= 4'd0;
            r_shift      <= 8'd0;
            r_baud       <= 8'd0;
            r_buf        <= 8'd0;
            r_quarter    <= 2'd0;
            r_ack_status <= 1'b0;
            r_ack_data   <= 1'b0;
            r_done       <= 1'b0;
            r_coll       <= 1'b0;
            r_scl        <= 1'b0;
            r_sda        <= 1'b0;
        end else if (i_adv) begin
            r_phase      <= n_phase;
            r_bit_cnt    <= n_bit_cnt;
            r_shift      <= n_shift;
            r_baud       <= n_baud;
            r_buf        <= n_buf;
            r_quarter    <= n_quarter;
            r_ack_status <= n_ack_status;
            r_ack_data   <= n_ack_data;
            r_done       <= n_done;
            r_coll       <= n_coll;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
        end
    end

    assign o_res.read_data    = w_rd;
    assign o_res.scl_pull_low = n_scl;
    assign o_res.sda_pull_low = n_sda;
    assign o_res.done_irq     = n_done;
    assign o_res.busy_res     = (n_phase != PH_IDLE);

`ifndef ASSERT_OFF
    a_buf_starts_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && (i_item.operation == OP_WRITE) && (i_item.reg_select == REG_BUF) &&
         (r_phase == PH_IDLE)) |=> (r_phase == PH_TX))
        else $error("buffer write while idle did not start a transmit");

    a_done_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) ##1 (r_phase == PH_IDLE) |-> r_done)
        else $error("sequence ended without setting the done flag");

    a_idle_counters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> ((r_baud == 8'd0) && (r_quarter == 2'd0) &&
                                  (r_bit_cnt == 4'd0)))
        else $error("counters not cleared while idle");

    a_tx_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_TX) |-> (r_bit_cnt <= ACK_SLOT))
        else $error("transmit bit counter past the ack slot");

    a_hold_no_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> ($stable(r_phase) && $stable(r_baud) && $stable(r_scl) && $stable(r_sda)))
        else $error("bus state moved without a transaction");
`endif

endmodule

### design/i2c_master_controller.sv
// channel   dir  handshake      payload
// i_item    in   valid/ready    operation, reg_select, write_data, sda_sample, scl_sample
// o_res     out  valid/ready    read_data, scl_pull_low, sda_pull_low, done_irq, busy_res
// apb       in   psel/penable   register 0 clock_divider at byte address 0
//
// one transaction per cycle sustained while the result side keeps taking results; an accepted
// item goes into the input register, then through the bus step into the result register,
// from which it is offered as the result
// a stalled result holds the input register; the input side takes one more item only if it is empty
// synchronous active-low reset clears bus state, flags and pins; divider returns to 3
module i2c_master_controller
    import i2cm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    i2cm_in_if.sink           i_item,
    i2cm_out_if.source        o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [1:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic       r_in_valid;
    t_item      r_in;
    logic       r_out_valid;
    t_result    r_out;
    logic       w_adv;
    logic       w_in_acc;
    logic [7:0] w_div;
    t_result    w_res;

    i2cm_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_div   (w_div)
    );

    i2cm_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_item  (r_in),
        .i_div   (w_div),
        .o_res   (w_res)
    );

    assign w_adv        = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_item.ready = !r_in_valid || w_adv;
    assign w_in_acc     = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in.operation  <= i_item.operation;
            r_in.reg_select <= i_item.reg_select;
            r_in.write_data <= i_item.write_data;
            r_in.sda_sample <= i_item.sda_sample;
            r_in.scl_sample <= i_item.scl_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.read_data    = r_out.read_data;
    assign o_res.scl_pull_low = r_out.scl_pull_low;
    assign o_res.sda_pull_low = r_out.sda_pull_low;
    assign o_res.done_irq     = r_out.done_irq;
    assign o_res.busy_res     = r_out.busy_res;

endmodule

### test/tb_top.sv
module tb_top;
    import i2cm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam logic [1:0] DIV_ADDR     = 2'd0;
    localparam logic [7:0] CTL_START    = 8'h01;
    localparam logic [7:0] CTL_RESTART  = 8'h02;
    localparam logic [7:0] CTL_STOP     = 8'h04;
    localparam logic [7:0] CTL_RX       = 8'h08;
    localparam logic [7:0] CTL_ACK      = 8'h10;
    localparam logic [7:0] CTL_ACK_DATA = 8'h20;
    localparam logic [7:0] STAT_BUSY    = 8'h01;
    localparam logic [2:0] QUARTERS     = 3'd4;
    localparam int         HOLD_CYCLES  = 80;
    localparam int         STALL_LIMIT  = 1000;
    localparam int         TAIL_CYCLES  = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    i2cm_in_if  item_ch();
    i2cm_out_if res_ch();

    i2c_master_controller uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 i_clk = ~i_clk;

    // bus model state
    t_phase     bm_phase   = PH_IDLE;
    logic [3:0] bm_bits    = '0;
    logic [7:0] bm_shift   = '0;
    logic [7:0] bm_baud    = '0;
    logic [2:0] bm_qtr     = '0;
    logic [7:0] bm_buffer  = '0;
    logic       bm_ackstat = 1'b0;
    logic       bm_ackbit  = 1'b0;
    logic       bm_done    = 1'b0;
    logic       bm_coll    = 1'b0;
    logic       bm_scl     = 1'b0;
    logic       bm_sda     = 1'b0;
    logic [7:0] bm_div     = DIV_RESET;

    t_result bus_expected[$];
    int      mismatches   = 0;
    bit      steady_flow  = 1'b0;
    int      holds_asked  = 0;
    int      holds_served = 0;
    int      hold_left    = 0;
    int      quiet_cycles = 0;

    function automatic bit bus_model_bitwise();
        return bm_phase == PH_TX || bm_phase == PH_RX || bm_phase == PH_ACK;
    endfunction

    function automatic void bus_model_drive();
        case (bm_phase)
            PH_START: begin
                bm_scl = (bm_qtr >= 3'd1);
                bm_sda = 1'b1;
            end
            PH_RESTART: begin
                bm_scl = (bm_qtr == 3'd0 || bm_qtr == 3'd3);
                bm_sda = (bm_qtr >= 3'd2);
            end
            PH_STOP: begin
                bm_scl = (bm_qtr == 3'd0);
                bm_sda = (bm_qtr <= 3'd1);
            end
            PH_TX: begin
                bm_scl = (bm_qtr < 3'd2);
                bm_sda = (bm_bits < ACK_SLOT) ? ~bm_shift[7] : 1'b0;
            end
            PH_RX: begin
                bm_scl = (bm_qtr < 3'd2);
                bm_sda = 1'b0;
            end
            PH_ACK: begin
                bm_scl = (bm_qtr < 3'd2);
                bm_sda = ~bm_ackbit;
            end
            default: ;
        endcase
    endfunction

    function automatic void bus_model_begin(input t_phase ph);
        bm_phase = ph;
        bm_bits  = '0;
        bm_qtr   = '0;
        bm_baud  = '0;
        if (ph == PH_RX) begin
            bm_shift = '0;
        end
        bus_model_drive();
    endfunction

    function automatic void bus_model_finish();
        if (bm_phase == PH_STOP) begin
            bm_scl = 1'b0;
            bm_sda = 1'b0;
        end else if (bus_model_bitwise()) begin
            if (bm_phase == PH_RX) begin
                bm_buffer = bm_shift;
            end
            bm_scl = 1'b1;
            bm_sda = 1'b0;
        end
        bm_phase = PH_IDLE;
        bm_bits  = '0;
        bm_qtr   = '0;
        bm_baud  = '0;
        bm_done  = 1'b1;
    endfunction

    function automatic void bus_model_tick(input logic sda, input logic scl);
        logic [3:0] nbits;
        logic [2:0] len;
        if (bm_phase == PH_IDLE) return;
        // slave stretching the clock
        if (!bm_scl && !scl) return;
        if (bm_baud < bm_div) begin
            bm_baud = bm_baud + 8'd1;
            return;
        end
        bm_baud = '0;
        if (bus_model_bitwise()) begin
            nbits = (bm_phase == PH_TX) ? NBITS_TX : (bm_phase == PH_RX) ? NBITS_RX : NBITS_ACK;
            if (bm_qtr == 3'd2) begin
                if (bm_phase == PH_TX && bm_bits == ACK_SLOT) begin
                    bm_ackstat = sda;
                end else if (bm_phase == PH_RX) begin
                    bm_shift = {bm_shift[6:0], sda};
                end
            end
            bm_qtr = bm_qtr + 3'd1;
            if (bm_qtr >= QUARTERS) begin
                bm_qtr = '0;
                if (bm_phase == PH_TX) begin
                    bm_shift = {bm_shift[6:0], 1'b0};
                end
                bm_bits = bm_bits + 4'd1;
                if (bm_bits >= nbits) begin
                    bus_model_finish();
                    return;
                end
            end
        end else begin
            len = (bm_phase == PH_START) ? LEN_START :
                  (bm_phase == PH_RESTART) ? LEN_RESTART : LEN_STOP;
            bm_qtr = bm_qtr + 3'd1;
            if (bm_qtr >= len) begin
                bus_model_finish();
                return;
            end
        end
        bus_model_drive();
    endfunction

    function automatic t_result predict_bus_step(input t_item it);
        t_result    r;
        logic [4:0] req;
        logic [7:0] ctl_bits;
        r        = '0;
        req      = it.write_data[4:0];
        ctl_bits = '0;
        case (it.operation)
            OP_TICK: bus_model_tick(it.sda_sample, it.scl_sample);
            OP_WRITE: begin
                case (it.reg_select)
                    REG_CTRL: begin
                        if (req != '0 && bm_phase != PH_IDLE) begin
                            bm_coll = 1'b1;
                        end else begin
                            bm_ackbit = it.write_data[CTL_ACK_BIT];
                            // lowest request bit wins
                            if (req[0]) bus_model_begin(PH_START);
                            else if (req[1]) bus_model_begin(PH_RESTART);
                            else if (req[2]) bus_model_begin(PH_STOP);
                            else if (req[3]) bus_model_begin(PH_RX);
                            else if (req[4]) bus_model_begin(PH_ACK);
                        end
                    end
                    REG_STAT: bm_coll = it.write_data[STAT_COLL];
                    REG_BUF: begin
                        if (bm_phase != PH_IDLE) begin
                            bm_coll = 1'b1;
                        end else begin
                            bm_buffer = it.write_data;
                            bm_shift  = it.write_data;
                            bus_model_begin(PH_TX);
                        end
                    end
                    default: bm_done = it.write_data[0];
                endcase
            end
            OP_READ: begin
                case (it.reg_select)
                    REG_CTRL: begin
                        case (bm_phase)
                            PH_START:   ctl_bits = CTL_START;
                            PH_RESTART: ctl_bits = CTL_RESTART;
                            PH_STOP:    ctl_bits = CTL_STOP;
                            PH_RX:      ctl_bits = CTL_RX;
                            PH_ACK:     ctl_bits = CTL_ACK;
                            default:    ctl_bits = '0;
                        endcase
                        ctl_bits[CTL_ACK_BIT]     = bm_ackbit;
                        ctl_bits[CTL_ACK_BIT + 1] = bm_ackstat;
                        r.read_data = ctl_bits;
                    end
                    REG_STAT: begin
                        r.read_data = ((bm_phase != PH_IDLE) ? STAT_BUSY : 8'h00) |
                                      ((bm_phase == PH_TX) ? STAT_TX : 8'h00);
                        r.read_data[STAT_COLL] = bm_coll;
                    end
                    REG_BUF: r.read_data = bm_buffer;
                    default: r.read_data = {7'd0, bm_done};
                endcase
            end
            default: ;
        endcase
        r.scl_pull_low = bm_scl;
        r.sda_pull_low = bm_sda;
        r.done_irq     = bm_done;
        r.busy_res     = (bm_phase != PH_IDLE);
        return r;
    endfunction

    function automatic t_item make_item(input logic [1:0] op, input logic [1:0] sel,
                                        input logic [7:0] d, input logic sda, input logic scl);
        t_item it;
        it.operation  = op;
        it.reg_select = sel;
        it.write_data = d;
        it.sda_sample = sda;
        it.scl_sample = scl;
        return it;
    endfunction

    // one request bit, sometimes with higher request bits that must be dropped
    function automatic logic [7:0] request_bits(input logic [4:0] onehot);
        logic [7:0] d;
        d      = 8'($urandom);
        d[4:0] = onehot;
        if ($urandom_range(4) == 0) begin
            d[4:0] = onehot | (5'($urandom) & ~((onehot << 1) - 5'd1));
        end
        return d;
    endfunction

    task automatic send_item(input t_item it);
        while (!steady_flow && $urandom_range(99) < 10) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.operation  <= it.operation;
        item_ch.reg_select <= it.reg_select;
        item_ch.write_data <= it.write_data;
        item_ch.sda_sample <= it.sda_sample;
        item_ch.scl_sample <= it.scl_sample;
        do @(posedge i_clk); while (!item_ch.ready);
        bus_expected.push_back(predict_bus_step(it));
    endtask

    task automatic bus_tick(input logic sda, input logic scl);
        send_item(make_item(OP_TICK, 2'($urandom), 8'($urandom), sda, scl));
    endtask

    task automatic reg_write(input logic [1:0] sel, input logic [7:0] d);
        send_item(make_item(OP_WRITE, sel, d, 1'($urandom), 1'($urandom)));
    endtask

    task automatic reg_read(input logic [1:0] sel);
        send_item(make_item(OP_READ, sel, 8'($urandom), 1'($urandom), 1'($urandom)));
    endtask

    task automatic run_bus_to_idle(input int stretch_pct);
        while (bm_phase != PH_IDLE) begin
            bus_tick(1'($urandom), ($urandom_range(99) < stretch_pct) ? 1'b0 : 1'b1);
        end
    endtask

    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        do @(posedge i_clk); while (bus_expected.size() != 0);
    endtask

    task automatic set_divider(input logic [7:0] v);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= DIV_ADDR;
        pwdata  <= {24'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        bm_div = v;
    endtask

    task automatic test_reset_values();
        reg_read(REG_CTRL);
        reg_read(REG_STAT);
        reg_read(REG_BUF);
        reg_read(REG_FLAG);
        bus_tick(1'b1, 1'b0);
        send_item(make_item(OP_UNUSED, REG_BUF, 8'hFF, 1'b1, 1'b1));
        reg_read(REG_BUF);
    endtask

    task automatic test_register_writes();
        reg_write(REG_STAT, 8'h80);
        reg_read(REG_STAT);
        reg_write(REG_STAT, 8'h7F);
        reg_write(REG_FLAG, 8'h01);
        reg_read(REG_FLAG);
        reg_write(REG_FLAG, 8'hFE);
        reg_write(REG_CTRL, CTL_ACK_DATA);
        reg_read(REG_CTRL);
        reg_write(REG_CTRL, 8'hC0);
        reg_read(REG_CTRL);
    endtask

    task automatic test_bus_sequences();
        reg_write(REG_CTRL, CTL_START);
        run_bus_to_idle(0);
        set_divider(8'd0);
        reg_write(REG_BUF, 8'hFF);
        run_bus_to_idle(0);
        reg_write(REG_BUF, 8'h00);
        run_bus_to_idle(0);
        reg_read(REG_CTRL);
        reg_write(REG_CTRL, CTL_RX);
        run_bus_to_idle(0);
        reg_read(REG_BUF);
        reg_write(REG_CTRL, CTL_ACK);
        run_bus_to_idle(0);
        reg_write(REG_CTRL, CTL_ACK | CTL_ACK_DATA);
        run_bus_to_idle(0);
        // several request bits, restart wins
        reg_write(REG_CTRL, 8'hFE);
        run_bus_to_idle(0);
        reg_write(REG_CTRL, CTL_STOP);
        run_bus_to_idle(0);
    endtask

    task automatic test_busy_collisions();
        reg_write(REG_CTRL, CTL_RX);
        repeat (5) bus_tick(1'($urandom), 1'b1);
        reg_write(REG_BUF, 8'hAA);
        reg_write(REG_CTRL, CTL_START);
        reg_write(REG_CTRL, CTL_ACK_DATA);
        reg_read(REG_STAT);
        reg_read(REG_CTRL);
        run_bus_to_idle(10);
        reg_write(REG_STAT, 8'h00);
        reg_read(REG_STAT);
    endtask

    task automatic test_clock_stretch();
        reg_write(REG_BUF, 8'h5A);
        repeat (10) bus_tick(1'($urandom), 1'b1);
        repeat (12) bus_tick(1'($urandom), 1'b0);
        run_bus_to_idle(30);
    endtask

    task automatic test_divider_extremes();
        set_divider(8'd255);
        reg_write(REG_CTRL, CTL_ACK);
        repeat (260) bus_tick(1'($urandom), 1'b1);
        // lower the divider below the running count
        set_divider(8'd3);
        run_bus_to_idle(0);
        set_divider(8'd0);
        reg_write(REG_BUF, 8'($urandom));
        run_bus_to_idle(5);
    endtask

    task automatic test_random_traffic(input int n_items, input logic [7:0] div,
                                       input bit steady, input bit squeeze);
        int sent;
        int pick;
        set_divider(div);
        steady_flow = steady;
        if (squeeze) begin
            holds_asked++;
        end
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 15) begin
                send_item(make_item(2'($urandom), 2'($urandom), 8'($urandom),
                                    1'($urandom), 1'($urandom)));
                sent++;
            end else begin
                pick = $urandom_range(5);
                if (pick == 5) begin
                    reg_write(REG_BUF, 8'($urandom));
                end else begin
                    reg_write(REG_CTRL, request_bits(5'd1 << pick));
                end
                sent++;
                while (bm_phase != PH_IDLE) begin
                    pick = $urandom_range(99);
                    if (pick < 6) begin
                        reg_read(2'($urandom));
                    end else if (pick < 8) begin
                        if ($urandom_range(1)) begin
                            reg_write(REG_BUF, 8'($urandom));
                        end else begin
                            reg_write(REG_CTRL, request_bits(5'd1 << $urandom_range(4)));
                        end
                    end else if (pick < 9) begin
                        reg_write(REG_CTRL, {3'($urandom), 5'd0});
                    end else begin
                        bus_tick(1'($urandom), ($urandom_range(99) < 4) ? 1'b0 : 1'b1);
                    end
                    sent++;
                end
                if ($urandom_range(2) == 0) begin
                    reg_read(REG_FLAG);
                    reg_write(REG_FLAG, 8'($urandom));
                    sent += 2;
                end
            end
        end
        steady_flow = 1'b0;
    endtask

    // result checker and receiver
    always @(posedge i_clk) begin
        t_result want;
        if (res_ch.valid && res_ch.ready) begin
            if (bus_expected.size() == 0) begin
                $error("unexpected result read_data %0h", res_ch.read_data);
                mismatches++;
            end else begin
                want = bus_expected.pop_front();
                if (res_ch.read_data !== want.read_data) begin
                    $error("read_data expected %0h got %0h", want.read_data, res_ch.read_data);
                    mismatches++;
                end
                if (res_ch.scl_pull_low !== want.scl_pull_low) begin
                    $error("scl_pull_low expected %0b got %0b",
                           want.scl_pull_low, res_ch.scl_pull_low);
                    mismatches++;
                end
                if (res_ch.sda_pull_low !== want.sda_pull_low) begin
                    $error("sda_pull_low expected %0b got %0b",
                           want.sda_pull_low, res_ch.sda_pull_low);
                    mismatches++;
                end
                if (res_ch.done_irq !== want.done_irq) begin
                    $error("done_irq expected %0b got %0b", want.done_irq, res_ch.done_irq);
                    mismatches++;
                end
                if (res_ch.busy_res !== want.busy_res) begin
                    $error("busy_res expected %0b got %0b", want.busy_res, res_ch.busy_res);
                    mismatches++;
                end
            end
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            res_ch.ready <= 1'b0;
        end else if (holds_served != holds_asked) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= steady_flow || ($urandom_range(99) >= 10);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        item_ch.valid      = 1'b0;
        item_ch.operation  = OP_TICK;
        item_ch.reg_select = REG_CTRL;
        item_ch.write_data = '0;
        item_ch.sda_sample = 1'b1;
        item_ch.scl_sample = 1'b1;
        res_ch.ready       = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = DIV_ADDR;
        pwdata             = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_register_writes();
        test_bus_sequences();
        test_busy_collisions();
        test_clock_stretch();
        test_divider_extremes();
        test_random_traffic(120, 8'd0, 1'b0, 1'b0);
        test_random_traffic(120, 8'd1, 1'b1, 1'b0);
        test_random_traffic(120, 8'd2, 1'b0, 1'b1);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
